// ----- design/acep_pkg.sv -----
// ----------------------------------------------------------------------------
// acep_pkg
// Shared types and constants for the ANSI colour escape parser.
// ----------------------------------------------------------------------------
package acep_pkg;

	localparam logic [7:0] BYTE_ESC   = 8'h1b;
	localparam logic [7:0] BYTE_BS    = 8'h08;
	localparam logic [7:0] BYTE_NL    = 8'h0a;
	localparam logic [7:0] BYTE_LEFTB = 8'h5b;
	localparam logic [7:0] BYTE_SEMI  = 8'h3b;
	localparam logic [7:0] BYTE_ZERO  = 8'h30;
	localparam logic [7:0] BYTE_ONE   = 8'h31;
	localparam logic [7:0] BYTE_THREE = 8'h33;
	localparam logic [7:0] BYTE_FOUR  = 8'h34;
	localparam logic [4:0] DIGIT_HI   = 5'b00110;
	localparam logic [7:0] ATTR_RESET = 8'h0f;
	localparam logic [7:0] ATTR_CLEAR = 8'h00;

	typedef enum logic [1:0] {
		ACT_PUT       = 2'd0,
		ACT_BACKSPACE = 2'd1,
		ACT_NEWLINE   = 2'd2
	} action_t;

	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_BEGIN = 8'b0000_0010,
		ST_LEFTB = 8'b0000_0100,
		ST_END   = 8'b0000_1000,
		ST_COLOR = 8'b0001_0000,
		ST_SEMIC = 8'b0010_0000,
		ST_FGBG  = 8'b0100_0000,
		ST_CODE  = 8'b1000_0000
	} parse_state_t;

	typedef enum logic [1:0] {
		TGT_NONE = 2'd0,
		TGT_FG   = 2'd1,
		TGT_BG   = 2'd2
	} target_t;

	typedef struct packed {
		logic        has_res;
		action_t     action;
		logic [15:0] cell_word;
	} acep_res_t;

endpackage

// ----- design/acep_parser.sv -----
// ----------------------------------------------------------------------------
// acep_parser
// Escape sequence state machine and colour attribute; decodes one byte per
// fire and returns the optional result.
// ----------------------------------------------------------------------------
module acep_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  logic [7:0]         char_byte,
	output acep_pkg::acep_res_t res
);
	import acep_pkg::*;

	parse_state_t state_q, state_d;
	logic [7:0]   attr_q, attr_d;
	target_t      target_q, target_d;
	logic         is_digit;

	assign is_digit = (char_byte[7:3] == DIGIT_HI);

	always_comb begin
		state_d       = ST_IDLE;
		attr_d        = attr_q;
		target_d      = target_q;
		res.has_res   = 1'b0;
		res.action    = ACT_PUT;
		res.cell_word = 16'h0000;
		unique case (state_q)
			ST_BEGIN: begin
				if (char_byte == BYTE_LEFTB)
					state_d = ST_LEFTB;
			end
			ST_LEFTB: begin
				if (char_byte == BYTE_ONE) begin
					state_d = ST_COLOR;
				end else if (char_byte == BYTE_ZERO) begin
					attr_d  = ATTR_CLEAR;
					state_d = ST_END;
				end
			end
			ST_COLOR: begin
				if (char_byte == BYTE_SEMI)
					state_d = ST_SEMIC;
			end
			ST_SEMIC: begin
				if (char_byte == BYTE_THREE) begin
					target_d = TGT_FG;
					state_d  = ST_FGBG;
				end else if (char_byte == BYTE_FOUR) begin
					target_d = TGT_BG;
					state_d  = ST_FGBG;
				end
			end
			ST_FGBG: begin
				if (is_digit) begin
					state_d = ST_CODE;
					if (target_q == TGT_FG)
						attr_d = {attr_q[7:4], 1'b1, char_byte[2:0]};
					else
						attr_d = {1'b1, char_byte[2:0], attr_q[3:0]};
				end
			end
			ST_END, ST_CODE: begin
				state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (char_byte == BYTE_BS) begin
					res.has_res = 1'b1;
					res.action  = ACT_BACKSPACE;
				end else if (char_byte == BYTE_NL) begin
					res.has_res = 1'b1;
					res.action  = ACT_NEWLINE;
				end else if (char_byte == BYTE_ESC) begin
					state_d  = ST_BEGIN;
					target_d = TGT_NONE;
				end else begin
					res.has_res   = 1'b1;
					res.cell_word = {attr_q, char_byte};
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			attr_q   <= ATTR_RESET;
			target_q <= TGT_NONE;
		end else if (fire) begin
			state_q  <= state_d;
			attr_q   <= attr_d;
			target_q <= target_d;
		end
	end

	a_res_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.has_res |-> state_q == ST_IDLE)
		else $error("result outside idle");

	a_cmd_word_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.has_res && res.action != ACT_PUT) |-> res.cell_word == 16'h0000)
		else $error("command with nonzero word");

	a_hold_no_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(state_q) && $stable(attr_q))
		else $error("parser state moved without a byte");

endmodule

// ----- design/ansi_color_escape_parser.sv -----
// ----------------------------------------------------------------------------
// ansi_color_escape_parser
// Text console front end: parses colour escape sequences and turns printable
// bytes into attributed cell words.
// ----------------------------------------------------------------------------
// Takes one byte per clock and gives one result per clock while the output is
// not stalled. A byte is held in the input register, is decoded by the parser
// state machine and its result lands in the output register. Bytes inside an
// escape sequence give no result. The output register parts the two sides: a
// new byte is still taken while a result waits, and input stalls only when
// both the input and output registers are full and the output is stalled.
module ansi_color_escape_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            char_byte,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            action,
	output logic [15:0]           cell_word
);
	import acep_pkg::*;

	logic      valid_s1;
	logic [7:0] byte_s1;
	logic      adv;
	acep_res_t res;
	logic      out_valid_q;
	logic [1:0] action_q;
	logic [15:0] cell_word_q;

	assign adv      = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			byte_s1 <= char_byte;
	end

	acep_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (adv),
		.char_byte (byte_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!(out_valid_q && out_stall)) begin
			out_valid_q <= adv && res.has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.has_res) begin
			action_q    <= res.action;
			cell_word_q <= res.cell_word;
		end
	end

	assign out_valid = out_valid_q;
	assign action    = action_q;
	assign cell_word = cell_word_q;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without output back-pressure");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1 && $stable(byte_s1))
		else $error("held byte lost or changed");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && res.has_res) |=> out_valid_q)
		else $error("decoded result not registered");

endmodule
